### rtl/fadd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fadd_pkg: shared constants for the binary32 adder.
// Bit-pattern constants and the result code for NaN outcomes (a zero operand passes a NaN through unchanged).
// ----------------------------------------------------------------------------
package fadd_pkg;
    localparam int unsigned WordWidth = 32;
    localparam logic [31:0] NanCode   = 32'h7FFF_FFFF;
    localparam logic [31:0] HiddenBit = 32'h4000_0000;
    localparam logic [22:0] MantMask  = 23'h7F_FFFF;
    localparam logic [7:0]  ExpMax    = 8'hFF;
    localparam logic [30:0] InfBits   = 31'h7F80_0000;
endpackage

### rtl/fadd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fadd_core: combinational binary32 addition.
// Aligns, adds, normalizes and rounds one operand pair to a result pattern.
// ----------------------------------------------------------------------------
module fadd_core (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_sum
);
    import fadd_pkg::*;

    logic [7:0]  ea, eb, eal, ebl;
    logic [22:0] ma, mb;
    logic [31:0] siga, sigb, al, bl, sum;
    logic [7:0]  dexp;
    logic [4:0]  sh;
    logic [8:0]  rexp;
    logic        sgn, a_big;
    logic [4:0]  lead;
    logic signed [10:0] e;
    logic [31:0] q, norm;
    logic [4:0]  drop;
    logic        rbit, sticky;
    logic [24:0] qr;
    logic [31:0] lmask;

    always_comb begin
        ea = i_a[30:23];
        eb = i_b[30:23];
        ma = i_a[22:0];
        mb = i_b[22:0];
        siga = {1'b0, (ea != 8'd0), ma, 7'd0};
        sigb = {1'b0, (eb != 8'd0), mb, 7'd0};
        eal = (ea == 8'd0) ? 8'd1 : ea;
        ebl = (eb == 8'd0) ? 8'd1 : eb;
        a_big = (eal >= ebl);
        dexp = a_big ? (eal - ebl) : (ebl - eal);
        sh = (dexp > 8'd31) ? 5'd31 : dexp[4:0];
        al = a_big ? siga : (siga >> sh);
        bl = a_big ? (sigb >> sh) : sigb;
        rexp = {1'b0, a_big ? eal : ebl};

        sgn = i_a[31];
        if (i_a[31] == i_b[31]) begin
            sum = al + bl;
        end else if (al > bl) begin
            sum = al - bl;
        end else if (al < bl) begin
            sum = bl - al;
            sgn = i_b[31];
        end else begin
            sum = '0;
            sgn = 1'b0;
        end

        // Leading-one position over the aligned sum.
        lead = '0;
        for (int i = 0; i < 32; i++) begin
            if (sum[i]) begin
                lead = 5'(i);
            end
        end
        e = $signed({2'b00, rexp}) + $signed({6'd0, lead}) - 11'sd30;

        drop = lead - 5'd23;
        lmask = (32'd1 << (drop - 5'd1)) - 32'd1;
        rbit = sum[drop - 5'd1];
        sticky = (sum & lmask) != 32'd0;
        q = sum >> drop;
        qr = q[24:0] + {24'd0, rbit & (sticky | q[0])};
        norm = '0;

        if (i_a == 32'd0) begin
            o_sum = i_b;
        end else if (i_b == 32'd0) begin
            o_sum = i_a;
        end else if ((ea == ExpMax && ma != 23'd0) || (eb == ExpMax && mb != 23'd0)) begin
            o_sum = NanCode;
        end else if (ea == ExpMax) begin
            o_sum = (eb == ExpMax && (i_a[31] != i_b[31])) ? NanCode : i_a;
        end else if (eb == ExpMax) begin
            o_sum = i_b;
        end else if (sum == 32'd0) begin
            o_sum = {sgn, 31'd0};
        end else if (e < 11'sd1) begin
            // Subnormal result is exact: scale the sum by 2^(rexp-8).
            // Here rexp stays below 31, so its low five bits hold it.
            if (rexp >= 9'd8) begin
                norm = sum << (rexp[4:0] - 5'd8);
            end else begin
                norm = sum >> (5'd8 - rexp[4:0]);
            end
            o_sum = {sgn, 8'd0, norm[22:0]};
        end else begin
            if (lead > 5'd23) begin
                if (qr[24]) begin
                    norm = {8'd0, qr[24:1]};
                    e = e + 11'sd1;
                end else begin
                    norm = {7'd0, qr};
                end
            end else begin
                norm = sum << (5'd23 - lead);
            end
            if (e >= 11'sd255) begin
                o_sum = {sgn, InfBits};
            end else begin
                o_sum = {sgn, e[7:0], norm[22:0] & MantMask};
            end
        end
    end
endmodule

### rtl/float32_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_adder: streaming binary32 adder.
// Registers an operand pair, adds it in one pass and holds the sum word
// in an output register until the downstream side takes it.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata fields (lowest bit first)
// s_axis    in         operand_a[31:0], operand_b[63:32]
// m_axis    out        sum_bits[31:0]
//
// Each word passes through the input register and then the result
// register. One word is taken per cycle while the output does not stall;
// the single pass through the adder sets this.
// Reset clears both valid flags only. A stall on the output holds the
// result register and, once the input register is also full, s_axis_tready.
// ----------------------------------------------------------------------------
module float32_adder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // sum_bits[31:0]
);
    import fadd_pkg::*;

    logic        r_in_vld, n_in_vld;
    logic [63:0] r_ops;
    logic        r_out_vld, n_out_vld;
    logic [31:0] r_sum;
    logic [31:0] sum;
    logic        out_load;

    fadd_core u_core (
        .i_a  (r_ops[31:0]),
        .i_b  (r_ops[63:32]),
        .o_sum(sum)
    );

    // The result register can load whenever it is empty or being drained.
    assign out_load      = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || out_load;
    assign n_out_vld     = out_load ? r_in_vld : r_out_vld;
    assign n_in_vld      = s_axis_tready ? s_axis_tvalid : r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_ops <= s_axis_tdata;
        end
        if (out_load && r_in_vld) begin
            r_sum <= sum;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_sum;

    // A stalled result must not be overwritten.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !m_axis_tready |=> r_out_vld && $stable(r_sum))
        else $error("result overwritten while stalled");
    // A word in the input register moves to the result register when it opens.
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && out_load |=> r_out_vld)
        else $error("word lost between registers");
    // Input is refused only when both registers are full and output stalls.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_vld && r_out_vld && !m_axis_tready)
        else $error("input refused without cause");
endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the streaming binary32 adder.
// A directed table covers zeros, NaNs, infinities, cancellation, overflow
// and subnormals; random operand pairs follow. Every sum word is compared with
// the table sum or a bit-exact behavioral adder, random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import fadd_pkg::*;

    localparam int NumRandom = 1150;
    localparam int CycleLimit = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;    // operand_a[31:0], operand_b[63:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // sum_bits[31:0]

    float32_adder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Directed row: operands and, where obvious, the sum (has_sum set).
    typedef struct {
        logic [31:0] op_a;
        logic [31:0] op_b;
        logic        has_sum;
        logic [31:0] sum;
    } t_add_row;

    logic [31:0] pending_sums[$];
    int          error_count = 0;
    int          cycle_count = 0;
    logic        feed_done = 1'b0;

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // Bit-exact sum with capped alignment, no alignment sticky bit, and RNE.
    function automatic logic [31:0] fadd_bits(logic [31:0] a, logic [31:0] b);
        logic [31:0] ea, eb, siga, sigb, acc, sgn, q, drop, shamt;
        logic [31:0] rexp;
        logic        rbit, sticky;
        int          lead, e;
        if (a == 32'd0) return b;
        if (b == 32'd0) return a;
        ea = {24'd0, a[30:23]};
        eb = {24'd0, b[30:23]};
        if (a[30:23] == ExpMax && a[22:0] != 23'd0) return NanCode;
        if (b[30:23] == ExpMax && b[22:0] != 23'd0) return NanCode;
        if (a[30:23] == ExpMax) begin
            if (b[30:23] == ExpMax && a[31] != b[31]) return NanCode;
            return a;
        end
        if (b[30:23] == ExpMax) return b;
        siga = {1'b0, (ea != 0), a[22:0], 7'd0};
        sigb = {1'b0, (eb != 0), b[22:0], 7'd0};
        if (ea < 1) ea = 1;
        if (eb < 1) eb = 1;
        if (ea >= eb) begin
            shamt = (ea - eb > 31) ? 31 : ea - eb;
            sigb = sigb >> shamt;
            rexp = ea;
        end else begin
            shamt = (eb - ea > 31) ? 31 : eb - ea;
            siga = siga >> shamt;
            rexp = eb;
        end
        sgn = {31'd0, a[31]};
        if (a[31] == b[31]) acc = siga + sigb;
        else if (siga > sigb) acc = siga - sigb;
        else if (siga < sigb) begin
            acc = sigb - siga;
            sgn = {31'd0, b[31]};
        end else begin
            acc = 0;
            sgn = 0;
        end
        if (acc == 0) return sgn << 31;
        lead = 0;
        for (int i = 0; i < 32; i++) if (acc[i]) lead = i;
        e = int'(rexp) + lead - 30;
        if (e < 1) begin
            q = (rexp >= 8) ? acc << (rexp - 8) : acc >> (8 - rexp);
            return {sgn[0], 8'd0, q[22:0]};
        end
        if (lead > 23) begin
            drop = lead - 23;
            rbit = acc[drop - 1];
            sticky = (acc & ((32'd1 << (drop - 1)) - 1)) != 0;
            q = acc >> drop;
            if (rbit && (sticky || q[0])) q = q + 1;
            if (q[24]) begin
                q = q >> 1;
                e = e + 1;
            end
        end else begin
            q = acc << (23 - lead);
        end
        if (e >= 255) return {sgn[0], InfBits};
        return {sgn[0], e[7:0], q[22:0]};
    endfunction

    // Gap lengths: mostly zero or short, occasionally long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random operand biased toward interesting exponents and patterns.
    function automatic logic [31:0] rand_operand();
        int          kind;
        logic [31:0] v;
        kind = $urandom_range(0, 19);
        v = $urandom;
        case (kind)
            0: v = 32'd0;
            1: v[30:23] = 8'hFF;
            2: v[30:23] = 8'd0;
            3: v[30:23] = 8'($urandom_range(252, 254));
            4: v[30:23] = 8'($urandom_range(1, 3));
            default: ;
        endcase
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the next call or the caller decides its level.
    task automatic push_pair(input logic [31:0] a, input logic [31:0] b,
                             input logic has_sum, input logic [31:0] sum);
        logic [31:0] model_sum;
        int          g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        model_sum = fadd_bits(a, b);
        if (has_sum && sum != model_sum)
            $display("%0t: table row %h + %h: typed %h, predicted %h",
                     $time, a, b, sum, model_sum);
        pending_sums.push_back(has_sum ? sum : model_sum);
        @(negedge i_clk);
    endtask

    // Stimulus: directed table, then random pairs. Valid is lowered only at
    // the start of a gap or after the last word, once per falling edge.
    initial begin
        t_add_row    rows[$];
        logic [31:0] a, b;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_rst_n       = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        rows = '{
            '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
            '{32'h0000_0000, 32'h7FC0_0001, 1'b1, 32'h7FC0_0001},
            '{32'hBF80_0000, 32'h0000_0000, 1'b1, 32'hBF80_0000},
            '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000},
            '{32'h7FC0_0000, 32'h3F80_0000, 1'b1, NanCode},
            '{32'h3F80_0000, 32'hFF80_0001, 1'b1, NanCode},
            '{32'h7F80_0000, 32'hFF80_0000, 1'b1, NanCode},
            '{32'h7F80_0000, 32'h7F80_0000, 1'b1, 32'h7F80_0000},
            '{32'hFF80_0000, 32'h3F80_0000, 1'b1, 32'hFF80_0000},
            '{32'h3F80_0000, 32'h7F80_0000, 1'b1, 32'h7F80_0000},
            '{32'h3F80_0000, 32'hBF80_0000, 1'b1, 32'h0000_0000},
            '{32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h4000_0000},
            '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1, 32'h7F80_0000},
            '{32'hFF7F_FFFF, 32'hFF7F_FFFF, 1'b1, 32'hFF80_0000},
            '{32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0002},
            '{32'h0080_0000, 32'h8000_0001, 1'b0, 32'h0},
            '{32'h007F_FFFF, 32'h0000_0001, 1'b0, 32'h0},
            '{32'h3F80_0000, 32'h3380_0000, 1'b0, 32'h0},
            '{32'h3F80_0000, 32'h3380_0001, 1'b0, 32'h0},
            '{32'h7F00_0000, 32'h0000_0001, 1'b0, 32'h0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NanCode},
            '{32'h3F80_0001, 32'hBF80_0000, 1'b0, 32'h0},
            '{32'h4B7F_FFFF, 32'h3F00_0000, 1'b0, 32'h0}
        };
        foreach (rows[i]) push_pair(rows[i].op_a, rows[i].op_b, rows[i].has_sum, rows[i].sum);
        for (int n = 0; n < NumRandom; n++) begin
            a = rand_operand();
            b = rand_operand();
            // Some pairs share or nearly share exponents to hit cancellation.
            if ($urandom_range(0, 3) == 0) begin
                b[30:23] = a[30:23] + 8'($urandom_range(0, 2));
                if ($urandom_range(0, 1) == 1) b[31] = ~a[31];
            end
            push_pair(a, b, 1'b0, 32'h0);
        end
        s_axis_tvalid <= 1'b0;
        feed_done = 1'b1;
    end

    // Downstream ready with random stalls, including stretches with none.
    initial begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            g = gap_len();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g - 1) @(negedge i_clk);
            end
        end
    end

    // Compare each accepted sum word with the oldest prediction.
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected sum word, expected none, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                want = pending_sums.pop_front();
                if (m_axis_tdata !== want) begin
                    $display("%0t: sum_bits mismatch, expected %h, actual %h",
                             $time, want, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    // Timeout is decided here; end of run is decided in the process below.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        wait (feed_done);
        wait (pending_sums.size() == 0);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_sums.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
